[rtl/kwm_pkg.sv]
// Package for the k-way sorted run merge block.
// Holds field widths, action codes, parameter defaults and shared types.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

    localparam int RUNS_DEF      = 8;
    localparam int RUN_DEPTH_DEF = 256;

    localparam int ACT_W      = 2;
    localparam int RUN_W      = 3;
    localparam int VAL_W      = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 1;

    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TAKE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_LAST,
        ST_POP
    } t_state;

    typedef struct packed {
        logic start;
        logic cmp_en;
        logic cand_vld;
    } t_min_ctl;

    typedef struct packed {
        logic in_rdy;
        logic scan;
        logic load_go;
        logic pop_go;
    } t_seq_ctl;

endpackage

`default_nettype wire

[rtl/k_way_sorted_run_merge.sv]
// Top level of the k-way sorted run merge block.
// Holds the sequencer and run pointers; uses kwm_store, kwm_min_unit and kwm_pkg.
//
// Words enter on the s_axis channel: tuser carries the action, tdata the run
// number and value. A load appends the value to its run, a take pops the
// smallest head over all runs, and a clear empties every run and the
// overflow flag. Only a take produces a word on the m_axis channel.
// A clear completes in the cycle it is accepted. A load is accepted and
// then does its pointer and memory write in the load state. A take holds
// off new words until it returns to idle: after the accepting cycle the
// heads are read one run per cycle through the single memory read port
// into one shared comparator, followed by a final compare cycle and a pop
// cycle that writes the result. The result word is held in an output
// register, so the next word can be accepted while it waits. If the
// receiver stalls and a new take finishes before the old result is taken,
// the pop cycle waits until it is.
// Reset empties all runs through their fill counts and clears the flag and
// the output valid; the memory itself needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module k_way_sorted_run_merge #(
    parameter int RUNS      = kwm_pkg::RUNS_DEF,
    parameter int RUN_DEPTH = kwm_pkg::RUN_DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // Fields from bit 0: run (3), value (16), zero padding.
    input  wire [kwm_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // Fields from bit 0: action (2).
    input  wire [kwm_pkg::ACT_W-1:0]           i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // Fields from bit 0: smallest (16), source_run (3), overflowed (1), zero padding.
    output logic [kwm_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // Fields from bit 0: all_empty (1).
    output logic [kwm_pkg::OUT_USER_W-1:0]     o_m_axis_tuser
);

    localparam int RW  = $clog2(RUNS);
    localparam int DW  = $clog2(RUN_DEPTH);
    localparam int AW  = RW + DW;
    localparam int RXW = (RW > kwm_pkg::RUN_W) ? RW : kwm_pkg::RUN_W;
    localparam int PAD = kwm_pkg::OUT_DATA_W - kwm_pkg::VAL_W - kwm_pkg::RUN_W - 1;

    kwm_pkg::t_state   r_state, n_state;
    kwm_pkg::t_seq_ctl w_ctl;
    kwm_pkg::t_min_ctl w_min_ctl;

    logic [DW:0]               r_fill [RUNS];
    logic [DW-1:0]             r_head [RUNS];
    logic                      r_ovf;
    logic [RW-1:0]             r_idx;
    logic [kwm_pkg::VAL_W-1:0] r_val;
    logic                      r_pend;
    logic [RW-1:0]             r_pend_run;
    logic                      r_out_vld;
    logic [kwm_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [kwm_pkg::OUT_USER_W-1:0] r_out_user;

    logic                      w_accept;
    logic [kwm_pkg::ACT_W-1:0] w_act;
    logic [RXW-1:0]            w_run_x;
    logic                      w_run_ok;
    logic [RW-1:0]             w_sel;
    logic [DW:0]               w_fill_sel;
    logic [DW-1:0]             w_head_sel;
    logic                      w_full;
    logic [DW:0]               w_sum;
    logic [DW-1:0]             w_tail;
    logic [DW-1:0]             w_head_inc;
    logic                      w_we;
    logic                      w_last_idx;
    logic [kwm_pkg::VAL_W-1:0] w_rdata;
    logic                      w_found;
    logic [kwm_pkg::VAL_W-1:0] w_best;
    logic [RW-1:0]             w_best_run;
    logic [RXW-1:0]            w_src_x;

    assign w_act    = i_s_axis_tuser;
    assign w_run_x  = RXW'(i_s_axis_tdata[kwm_pkg::RUN_W-1:0]);
    assign w_run_ok = 32'(w_run_x) < 32'(RUNS);
    assign w_accept = i_s_axis_tvalid && w_ctl.in_rdy;

    assign w_sel      = (r_state == kwm_pkg::ST_POP) ? w_best_run : r_idx;
    assign w_fill_sel = r_fill[w_sel];
    assign w_head_sel = r_head[w_sel];
    assign w_full     = w_fill_sel == (DW+1)'(RUN_DEPTH);
    assign w_sum      = {1'b0, w_head_sel} + w_fill_sel;
    assign w_tail     = (w_sum >= (DW+1)'(RUN_DEPTH)) ? DW'(w_sum - (DW+1)'(RUN_DEPTH))
                                                      : DW'(w_sum);
    assign w_head_inc = (w_head_sel == DW'(RUN_DEPTH - 1)) ? '0 : w_head_sel + 1'b1;
    assign w_we       = w_ctl.load_go && !w_full;
    assign w_last_idx = r_idx == RW'(RUNS - 1);
    assign w_src_x    = RXW'(w_best_run);

    always_comb begin
        n_state = r_state;
        case (r_state)
            kwm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (w_act == kwm_pkg::ACT_LOAD && w_run_ok) begin
                        n_state = kwm_pkg::ST_LOAD;
                    end else if (w_act == kwm_pkg::ACT_TAKE) begin
                        n_state = kwm_pkg::ST_SCAN;
                    end
                end
            end
            kwm_pkg::ST_LOAD: begin
                n_state = kwm_pkg::ST_IDLE;
            end
            kwm_pkg::ST_SCAN: begin
                if (w_last_idx) begin
                    n_state = kwm_pkg::ST_LAST;
                end
            end
            kwm_pkg::ST_LAST: begin
                n_state = kwm_pkg::ST_POP;
            end
            kwm_pkg::ST_POP: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_state = kwm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kwm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctl = '0;
        case (r_state)
            kwm_pkg::ST_IDLE: w_ctl.in_rdy  = 1'b1;
            kwm_pkg::ST_LOAD: w_ctl.load_go = 1'b1;
            kwm_pkg::ST_SCAN: w_ctl.scan    = 1'b1;
            kwm_pkg::ST_POP:  w_ctl.pop_go  = !r_out_vld || i_m_axis_tready;
            default:          w_ctl         = '0;
        endcase
    end

    assign w_min_ctl.start    = w_accept && (w_act == kwm_pkg::ACT_TAKE);
    assign w_min_ctl.cmp_en   = (r_state == kwm_pkg::ST_SCAN) || (r_state == kwm_pkg::ST_LAST);
    assign w_min_ctl.cand_vld = r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kwm_pkg::ST_IDLE;
            r_ovf     <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < RUNS; i++) begin
                r_fill[i] <= '0;
                r_head[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pend  <= w_ctl.scan && (w_fill_sel != '0);
            if (w_ctl.pop_go) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (w_accept && w_act == kwm_pkg::ACT_CLEAR) begin
                r_ovf <= 1'b0;
                for (int i = 0; i < RUNS; i++) begin
                    r_fill[i] <= '0;
                    r_head[i] <= '0;
                end
            end
            if (w_ctl.load_go) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_fill[w_sel] <= w_fill_sel + 1'b1;
                end
            end
            if (w_ctl.pop_go && w_found) begin
                r_fill[w_sel] <= w_fill_sel - 1'b1;
                r_head[w_sel] <= w_head_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val <= i_s_axis_tdata[kwm_pkg::RUN_W +: kwm_pkg::VAL_W];
            r_idx <= (w_act == kwm_pkg::ACT_TAKE) ? '0 : w_run_x[RW-1:0];
        end else if (w_ctl.scan && !w_last_idx) begin
            r_idx <= r_idx + 1'b1;
        end
        r_pend_run <= r_idx;
        if (w_ctl.pop_go) begin
            r_out_data <= {{PAD{1'b0}}, r_ovf,
                           w_found ? w_src_x[kwm_pkg::RUN_W-1:0] : {kwm_pkg::RUN_W{1'b0}},
                           w_found ? w_best : {kwm_pkg::VAL_W{1'b0}}};
            r_out_user <= {!w_found};
        end
    end

    kwm_store #(
        .AW (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({w_sel, w_tail}),
        .i_wdata (r_val),
        .i_raddr ({w_sel, w_head_sel}),
        .o_rdata (w_rdata)
    );

    kwm_min_unit #(
        .RUNS (RUNS)
    ) u_min (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_min_ctl),
        .i_cand_val (w_rdata),
        .i_cand_run (r_pend_run),
        .o_found    (w_found),
        .o_best     (w_best),
        .o_best_run (w_best_run)
    );

    assign o_s_axis_tready = w_ctl.in_rdy;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

[rtl/kwm_store.sv]
// Run storage memory for the k-way sorted run merge block.
// One write port and one read port with registered read data.
// Depends on kwm_pkg for the value width.
`timescale 1ns / 1ps
`default_nettype none

module kwm_store #(
    parameter int AW = 11
) (
    input  wire                        i_clk,
    input  wire                        i_we,
    input  wire [AW-1:0]               i_waddr,
    input  wire [kwm_pkg::VAL_W-1:0]   i_wdata,
    input  wire [AW-1:0]               i_raddr,
    output logic [kwm_pkg::VAL_W-1:0]  o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic [kwm_pkg::VAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/kwm_min_unit.sv]
// Shared compare unit for the k-way sorted run merge block.
// Keeps the smallest candidate seen during a scan, ties to the earlier run.
// Depends on kwm_pkg for the control struct and the value width.
`timescale 1ns / 1ps
`default_nettype none

module kwm_min_unit #(
    parameter int RUNS = kwm_pkg::RUNS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire kwm_pkg::t_min_ctl          i_ctl,
    input  wire [kwm_pkg::VAL_W-1:0]        i_cand_val,
    input  wire [$clog2(RUNS)-1:0]          i_cand_run,
    output logic                            o_found,
    output logic [kwm_pkg::VAL_W-1:0]       o_best,
    output logic [$clog2(RUNS)-1:0]         o_best_run
);

    logic w_take;

    assign w_take = i_ctl.cmp_en && i_ctl.cand_vld && (!o_found || (i_cand_val < o_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_found <= 1'b0;
        end else if (i_ctl.start) begin
            o_found <= 1'b0;
        end else if (w_take) begin
            o_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            o_best     <= i_cand_val;
            o_best_run <= i_cand_run;
        end
    end

endmodule

`default_nettype wire
